// ===== hw/rtl/ape_pkg.sv =====
// Shared constants and types for the axis projection extent block.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package ape_pkg;

    // Width of the configuration register index.
    localparam int CFG_IDX_W = 3;

    // Projections are Q(31-F).F in 32 bits.
    localparam int PROJ_W = 32;

    // Queue between front and back: depth, pointer and occupancy widths.
    localparam int QDEPTH = 8;
    localparam int QPTR_W = 3;
    localparam int QCNT_W = 4;

    // Integer part of the start magnitude of the running extremes.
    localparam int START_UNITS = 1000;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_X   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_Y   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_Z   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_INV_LEN  = 3'd6;

    // Queue status seen by the back end and the top level.
    typedef struct packed {
        logic empty;
        logic full;
    } ape_q_status_t;

endpackage

// ===== hw/rtl/ape_if.sv =====
// Channel interfaces of the axis projection extent block: points in,
// configuration writes in, results out. Depends on ape_pkg.
`timescale 1ns / 1ps

interface ape_point_if #(parameter int COORD_WIDTH = 24);
    import ape_pkg::*;
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;
    logic                          last_point;

    modport source (output valid, point_x, point_y, point_z, last_point, input ready);
    modport sink   (input valid, point_x, point_y, point_z, last_point, output ready);
endinterface

interface ape_cfg_if #(parameter int DATA_W = 24);
    import ape_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

interface ape_result_if #(parameter int COORD_WIDTH = 24);
    import ape_pkg::*;
    logic                          valid;
    logic                          ready;
    logic signed [PROJ_W-1:0]      min_projection;
    logic signed [PROJ_W-1:0]      max_projection;
    logic signed [COORD_WIDTH-1:0] min_point_x;
    logic signed [COORD_WIDTH-1:0] min_point_y;
    logic signed [COORD_WIDTH-1:0] min_point_z;
    logic signed [COORD_WIDTH-1:0] max_point_x;
    logic signed [COORD_WIDTH-1:0] max_point_y;
    logic signed [COORD_WIDTH-1:0] max_point_z;

    modport source (output valid, min_projection, max_projection, min_point_x, min_point_y,
                    min_point_z, max_point_x, max_point_y, max_point_z, input ready);
    modport sink   (input valid, min_projection, max_projection, min_point_x, min_point_y,
                    min_point_z, max_point_x, max_point_y, max_point_z, output ready);
endinterface

// ===== hw/rtl/ape_front.sv =====
// Front end: configuration registers, point intake with queue credits and
// the six-stage projection pipeline. Depends on ape_pkg and ape_if.
`timescale 1ns / 1ps

module ape_front #(
    parameter int COORD_WIDTH = 24,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    ape_point_if.sink                                   points,
    ape_cfg_if.sink                                     cfg,
    input  logic                                        q_pop,
    output logic                                        q_push,
    output logic [ape_pkg::PROJ_W+3*COORD_WIDTH:0]      q_wdata
);
    import ape_pkg::*;

    localparam int C    = COORD_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int AXW  = F + 2;
    localparam int DW   = C + 1;
    localparam int PW   = DW + AXW;
    localparam int SW   = PW + 2;
    localparam int MWP  = (SW > 32) ? SW : 33;
    localparam int HIW  = MWP - 32;
    localparam int LOP  = 32 + AXW;
    localparam int HIP  = HIW + AXW;
    localparam int TW   = MWP + AXW + 1;
    localparam int QW   = TW - 2 * F;
    localparam int QX   = (QW > 33) ? QW : 33;
    localparam int NSTG = 6;

    localparam logic [AXW-1:0] ONE_Q   = AXW'(1) << F;
    localparam logic [TW-1:0]  HALF    = TW'(1) << (2 * F - 1);
    localparam logic [QX-1:0]  SAT_NEG = QX'(64'h0000_0000_8000_0000);
    localparam logic [QX-1:0]  SAT_POS = QX'(64'h0000_0000_7FFF_FFFF);

    logic signed [C-1:0]   center_reg [3];
    logic signed [AXW-1:0] axis_reg [3];
    logic [AXW-1:0]        inv_reg;

    logic [QCNT_W-1:0]     outstanding_reg;
    logic [QCNT_W-1:0]     outstanding_next;
    logic                  in_accept;

    logic signed [C-1:0]   in_pt [3];
    logic signed [DW-1:0]  diff_next [3];
    logic signed [DW-1:0]  diff_reg [3];
    logic signed [PW-1:0]  prod_reg [3];
    logic signed [SW-1:0]  dot_reg;
    logic [SW-1:0]         mag_c;
    logic [MWP-1:0]        mag4_reg;
    logic [LOP-1:0]        lo5_reg;
    logic [HIP-1:0]        hi5_reg;
    logic [TW-1:0]         sum_c;
    logic [QW-1:0]         q6_reg;
    logic [QX-1:0]         q_ext;
    logic [PROJ_W-1:0]     sat_c;
    logic [PROJ_W-1:0]     proj_c;

    logic                  neg4_reg;
    logic                  neg5_reg;
    logic                  neg6_reg;
    logic [3*C-1:0]        pt_pipe [1:NSTG];
    logic                  last_pipe [1:NSTG];
    logic [NSTG:1]         vld_reg;

    // Configuration writes are always taken; unknown indexes are dropped.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg[0] <= '0;
            center_reg[1] <= '0;
            center_reg[2] <= '0;
            axis_reg[0]   <= ONE_Q;
            axis_reg[1]   <= '0;
            axis_reg[2]   <= '0;
            inv_reg       <= ONE_Q;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_CENTER_X: center_reg[0] <= cfg.data[C-1:0];
                REG_CENTER_Y: center_reg[1] <= cfg.data[C-1:0];
                REG_CENTER_Z: center_reg[2] <= cfg.data[C-1:0];
                REG_AXIS_X:   axis_reg[0]   <= cfg.data[AXW-1:0];
                REG_AXIS_Y:   axis_reg[1]   <= cfg.data[AXW-1:0];
                REG_AXIS_Z:   axis_reg[2]   <= cfg.data[AXW-1:0];
                REG_INV_LEN:  inv_reg       <= cfg.data[AXW-1:0];
                default:      ;
            endcase
        end
    end

    // Credits: a point is taken only when the queue is sure to have room for it.
    assign points.ready = (outstanding_reg < QCNT_W'(QDEPTH));
    assign in_accept    = points.valid && points.ready;

    always_comb
    begin
        outstanding_next = outstanding_reg;
        case ({in_accept, q_pop})
            2'b10:   outstanding_next = outstanding_reg + QCNT_W'(1);
            2'b01:   outstanding_next = outstanding_reg - QCNT_W'(1);
            default: outstanding_next = outstanding_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= '0;
            vld_reg         <= '0;
        end
        else
        begin
            outstanding_reg <= outstanding_next;
            vld_reg         <= {vld_reg[NSTG-1:1], in_accept};
        end
    end

    assign in_pt[0] = points.point_x;
    assign in_pt[1] = points.point_y;
    assign in_pt[2] = points.point_z;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            diff_next[i] = DW'(in_pt[i]) - DW'(center_reg[i]);
        end
        mag_c  = dot_reg[SW-1] ? (SW'(0) - SW'(dot_reg)) : SW'(dot_reg);
        sum_c  = (TW'(hi5_reg) << 32) + TW'(lo5_reg) + HALF;
        q_ext  = QX'(q6_reg);
        if (neg6_reg)
        begin
            sat_c  = (q_ext > SAT_NEG) ? PROJ_W'(SAT_NEG) : q_ext[PROJ_W-1:0];
            proj_c = PROJ_W'(0) - sat_c;
        end
        else
        begin
            sat_c  = (q_ext > SAT_POS) ? PROJ_W'(SAT_POS) : q_ext[PROJ_W-1:0];
            proj_c = sat_c;
        end
    end

    // Datapath stages run every cycle; the valid chain marks live points.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            diff_reg[i] <= diff_next[i];
            prod_reg[i] <= PW'(diff_reg[i]) * PW'(axis_reg[i]);
        end
        dot_reg  <= SW'(prod_reg[0]) + SW'(prod_reg[1]) + SW'(prod_reg[2]);
        neg4_reg <= dot_reg[SW-1];
        mag4_reg <= MWP'(mag_c);
        neg5_reg <= neg4_reg;
        lo5_reg  <= LOP'(mag4_reg[31:0]) * LOP'(inv_reg);
        hi5_reg  <= HIP'(mag4_reg[MWP-1:32]) * HIP'(inv_reg);
        neg6_reg <= neg5_reg;
        q6_reg   <= sum_c[TW-1:2*F];

        pt_pipe[1]   <= {points.point_x, points.point_y, points.point_z};
        last_pipe[1] <= points.last_point;
        for (int s = 2; s <= NSTG; s++)
        begin
            pt_pipe[s]   <= pt_pipe[s-1];
            last_pipe[s] <= last_pipe[s-1];
        end
    end

    assign q_push  = vld_reg[NSTG];
    assign q_wdata = {proj_c, pt_pipe[NSTG], last_pipe[NSTG]};

endmodule

// ===== hw/rtl/ape_queue.sv =====
// Small first-in first-out queue between front and back end.
// Depends on ape_pkg for depth and status type.
`timescale 1ns / 1ps

module ape_queue #(
    parameter int ENTRY_W = 105
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  logic [ENTRY_W-1:0]     wdata,
    input  logic                   pop,
    output logic [ENTRY_W-1:0]     rdata,
    output ape_pkg::ape_q_status_t stat
);
    import ape_pkg::*;

    logic [ENTRY_W-1:0] slot_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_comb
    begin
        case ({push, pop})
            2'b10:   count_next = count_reg + QCNT_W'(1);
            2'b01:   count_next = count_reg - QCNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    assign rdata      = slot_reg[rd_ptr_reg];
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == QCNT_W'(QDEPTH));

endmodule

// ===== hw/rtl/ape_back.sv =====
// Back end: running minimum and maximum tracker and the result register.
// Depends on ape_pkg and ape_if.
`timescale 1ns / 1ps

module ape_back #(
    parameter int COORD_WIDTH = 24,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  ape_pkg::ape_q_status_t                 q_stat,
    input  logic [ape_pkg::PROJ_W+3*COORD_WIDTH:0] q_rdata,
    output logic                                   q_pop,
    ape_result_if.source                           results
);
    import ape_pkg::*;

    localparam int C  = COORD_WIDTH;
    localparam int EW = PROJ_W + 3 * C + 1;

    localparam logic signed [PROJ_W-1:0] START_POS =
        PROJ_W'(START_UNITS * (2 ** FRAC_BITS));
    localparam logic signed [PROJ_W-1:0] START_NEG = PROJ_W'(0) - START_POS;

    logic signed [PROJ_W-1:0] proj;
    logic [3*C-1:0]           pt;
    logic                     last;
    logic                     lt;
    logic                     gt;

    logic signed [PROJ_W-1:0] run_min_reg;
    logic signed [PROJ_W-1:0] run_max_reg;
    logic [3*C-1:0]           min_pt_reg;
    logic [3*C-1:0]           max_pt_reg;
    logic signed [PROJ_W-1:0] run_min_next;
    logic signed [PROJ_W-1:0] run_max_next;
    logic [3*C-1:0]           min_pt_next;
    logic [3*C-1:0]           max_pt_next;

    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic signed [PROJ_W-1:0] out_min_reg;
    logic signed [PROJ_W-1:0] out_max_reg;
    logic [3*C-1:0]           out_min_pt_reg;
    logic [3*C-1:0]           out_max_pt_reg;

    assign proj = q_rdata[EW-1 -: PROJ_W];
    assign pt   = q_rdata[3*C:1];
    assign last = q_rdata[0];

    // Strict compares keep the earliest point on ties.
    assign lt = (proj < run_min_reg);
    assign gt = (proj > run_max_reg);

    assign run_min_next = lt ? proj : run_min_reg;
    assign run_max_next = gt ? proj : run_max_reg;
    assign min_pt_next  = lt ? pt : min_pt_reg;
    assign max_pt_next  = gt ? pt : max_pt_reg;

    // A last point needs the result register free; other points never wait.
    assign q_pop = !q_stat.empty && (!last || !out_valid_reg || results.ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (q_pop && last)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_min_reg   <= START_POS;
            run_max_reg   <= START_NEG;
            min_pt_reg    <= '0;
            max_pt_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (q_pop)
            begin
                if (last)
                begin
                    run_min_reg <= START_POS;
                    run_max_reg <= START_NEG;
                    min_pt_reg  <= '0;
                    max_pt_reg  <= '0;
                end
                else
                begin
                    run_min_reg <= run_min_next;
                    run_max_reg <= run_max_next;
                    min_pt_reg  <= min_pt_next;
                    max_pt_reg  <= max_pt_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && last)
        begin
            out_min_reg    <= run_min_next;
            out_max_reg    <= run_max_next;
            out_min_pt_reg <= min_pt_next;
            out_max_pt_reg <= max_pt_next;
        end
    end

    assign results.valid          = out_valid_reg;
    assign results.min_projection = out_min_reg;
    assign results.max_projection = out_max_reg;
    assign results.min_point_x    = out_min_pt_reg[3*C-1:2*C];
    assign results.min_point_y    = out_min_pt_reg[2*C-1:C];
    assign results.min_point_z    = out_min_pt_reg[C-1:0];
    assign results.max_point_x    = out_max_pt_reg[3*C-1:2*C];
    assign results.max_point_y    = out_max_pt_reg[2*C-1:C];
    assign results.max_point_z    = out_max_pt_reg[C-1:0];

endmodule

// ===== hw/rtl/axis_projection_extent_core.sv =====
// A last point's result passes the projection pipeline, the queue and the output register.
// Throughput: one point per cycle while credits remain on the 8-entry front/back queue.
// Results wait in an output register. Points keep flowing while it is held until the next
// last point reaches the back end; intake then stops once the queue credits are used up.
// Reset (rst_n, asynchronous, active low): config to defaults, extremes to +/-1000.0,
// stored points to zero, pipeline and queue empty. There is no clearing pass.
`timescale 1ns / 1ps

module axis_projection_extent_core #(
    parameter int COORD_WIDTH = 24,
    parameter int FRAC_BITS   = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    ape_point_if.sink    points,
    ape_cfg_if.sink      cfg,
    ape_result_if.source results
);
    import ape_pkg::*;

    // Queue entry: projection, the three raw coordinates, last flag.
    localparam int ENTRY_W = PROJ_W + 3 * COORD_WIDTH + 1;

    logic               q_push;
    logic               q_pop;
    logic [ENTRY_W-1:0] q_wdata;
    logic [ENTRY_W-1:0] q_rdata;
    ape_q_status_t      q_stat;

    // The front end computes the saturated projection of every point. Its
    // pipeline never stalls: points are only taken while the number of
    // points in flight plus those queued stays below the queue depth.
    ape_front #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .points  (points),
        .cfg     (cfg),
        .q_pop   (q_pop),
        .q_push  (q_push),
        .q_wdata (q_wdata)
    );

    // The queue decouples the projection pipeline from the tracker so that
    // a stalled result does not stop the intake of points until the credits are used up.
    ape_queue #(
        .ENTRY_W (ENTRY_W)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .stat  (q_stat)
    );

    // The back end folds each projection into the running extremes and, on
    // the last point of a cloud, loads the result register and starts over.
    ape_back #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_stat  (q_stat),
        .q_rdata (q_rdata),
        .q_pop   (q_pop),
        .results (results)
    );

    // The credit scheme must keep the queue from overflowing.
    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("queue push while full");

    a_pop_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("queue pop while empty");

    // A result appears only after the tracker took a last point.
    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(results.valid) |-> $past(q_pop && q_rdata[0]))
        else $error("result without a last point");

endmodule
